// ----- hdl/mlfc_pkg.sv -----
package mlfc_pkg;

	localparam int TICK_W = 16;
	localparam int PIN_W  = 8;

	localparam logic [2:0] CMD_TICK       = 3'd0;
	localparam logic [2:0] CMD_ON         = 3'd1;
	localparam logic [2:0] CMD_OFF        = 3'd2;
	localparam logic [2:0] CMD_FLASH      = 3'd3;
	localparam logic [2:0] CMD_FLASH_ONCE = 3'd4;

	localparam logic [1:0] MODE_OFF   = 2'd0;
	localparam logic [1:0] MODE_ON    = 2'd1;
	localparam logic [1:0] MODE_FLASH = 2'd2;

	typedef struct packed {
		logic [1:0]        mode;
		logic              phase;
		logic              pend;
		logic [TICK_W-1:0] lit;
		logic [TICK_W-1:0] dark;
		logic [TICK_W-1:0] rem;
	} chan_t;

	localparam int CHAN_W = $bits(chan_t);

	function automatic chan_t fire_chan(chan_t c);
		chan_t r;
		r = c;
		r.phase = !c.phase;
		if (r.phase) begin
			r.rem  = c.lit;
			r.pend = 1'b1;
		end else if (c.dark != '0) begin
			r.rem  = c.dark;
			r.pend = 1'b1;
		end else begin
			r.pend = 1'b0;
		end
		return r;
	endfunction

endpackage

// ----- hdl/mlfc_ram.sv -----
module mlfc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- hdl/multi_led_flash_controller_unit.sv -----
// LED flash controller for NUM_CHANNELS channels.
// Input channel (in_valid / in_stall): one request carries command, led_index,
// on_time and off_time. Commands: tick, on, off, flash, flash once.
// Output channel (out_valid / out_stall): one result per request with the
// pin levels of channels 0..7, the mode of the addressed channel and its
// active flag.
// Config channel (cfg_valid / cfg_ready): writes active_level_mask; write it
// only while no request is in flight. It applies the next time a pin is driven.
// Channel state sits in one RAM entry per channel and is read, modified and
// written back. A tick walks all channels through the RAM port, one per cycle.
// Flow: an accepted tick walks the channels in S_TICK, any other command is
// applied in S_CMD; both then move to S_OUT, which loads the result into the
// output register, and the block returns to S_IDLE to take the next request.
// The next request is accepted while a result still waits in the output
// register; the block stalls its input only while a request is being
// processed or while that request's result waits for a free output register.
// Reset clears pins, mask, modes and timers at once; no clearing pass.
module multi_led_flash_controller_unit import mlfc_pkg::*; #(
	parameter int NUM_CHANNELS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [2:0]        command,
	input  logic [2:0]        led_index,
	input  logic [TICK_W-1:0] on_time,
	input  logic [TICK_W-1:0] off_time,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [PIN_W-1:0]  pin_levels,
	output logic [1:0]        mode_of_led,
	output logic              led_active,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [PIN_W-1:0]  active_level_mask
);

	localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int CW = $clog2(NUM_CHANNELS + 1);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_TICK = 4'b0010,
		S_CMD  = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	state_t                  state_q;
	logic [2:0]              cmd_q;
	logic [2:0]              idx_q;
	logic [TICK_W-1:0]       on_q;
	logic [TICK_W-1:0]       off_q;
	logic [CW-1:0]           cnt_q;
	logic [AW-1:0]           ch_s1;
	logic                    vld_s1;
	logic [NUM_CHANNELS-1:0] valid_q;
	logic [PIN_W-1:0]        mask_q;
	logic [PIN_W-1:0]        pin_q;
	logic [1:0]              res_mode_q;
	logic                    out_valid_q;
	logic [PIN_W-1:0]        out_pin_q;
	logic [1:0]              out_mode_q;

	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [CHAN_W-1:0] rd_data;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	chan_t             cur;
	chan_t             nxt;
	logic              drive;
	logic              lit;
	logic [PIN_W-1:0]  pin_d;
	logic              idx_ok;
	logic              out_load;

	mlfc_ram #(
		.WIDTH(CHAN_W),
		.DEPTH(NUM_CHANNELS),
		.AW   (AW)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(nxt),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign in_stall    = (state_q != S_IDLE);
	assign cfg_ready   = 1'b1;
	assign out_valid   = out_valid_q;
	assign pin_levels  = out_pin_q;
	assign mode_of_led = out_mode_q;
	assign led_active  = (out_mode_q != MODE_OFF);

	assign idx_ok   = int'(idx_q) < NUM_CHANNELS;
	assign cur      = vld_s1 ? chan_t'(rd_data) : '0;
	assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = cnt_q[AW-1:0];
		case (state_q)
			S_IDLE: begin
				rd_en   = in_valid;
				rd_addr = (command == CMD_TICK) ? '0 : AW'(led_index);
			end
			S_TICK: begin
				rd_en = (cnt_q < CW'(NUM_CHANNELS));
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_comb begin
		nxt     = cur;
		drive   = 1'b0;
		lit     = 1'b0;
		wr_en   = 1'b0;
		wr_addr = ch_s1;
		pin_d   = pin_q;
		case (state_q)
			S_TICK: begin
				wr_en = 1'b1;
				if (cur.pend) begin
					if (cur.rem <= TICK_W'(1)) begin
						nxt   = fire_chan(cur);
						drive = 1'b1;
						lit   = nxt.phase;
					end else begin
						nxt.rem = cur.rem - TICK_W'(1);
					end
				end
			end
			S_CMD: begin
				wr_addr = AW'(idx_q);
				if (idx_ok) begin
					case (cmd_q)
						CMD_ON: begin
							nxt.mode = MODE_ON;
							nxt.pend = 1'b0;
							drive    = 1'b1;
							lit      = 1'b1;
						end
						CMD_OFF: begin
							nxt.mode = MODE_OFF;
							nxt.pend = 1'b0;
							drive    = 1'b1;
							lit      = 1'b0;
						end
						CMD_FLASH, CMD_FLASH_ONCE: begin
							nxt.mode  = MODE_FLASH;
							nxt.phase = 1'b1;
							nxt.lit   = on_q;
							nxt.dark  = (cmd_q == CMD_FLASH) ? off_q : '0;
							nxt.rem   = on_q;
							nxt.pend  = 1'b1;
							drive     = 1'b1;
							lit       = 1'b1;
						end
						default: begin
							drive = 1'b0;
						end
					endcase
				end
				wr_en = drive;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
		if (drive && (int'(wr_addr) < PIN_W)) begin
			pin_d[3'(wr_addr)] = lit ~^ mask_q[3'(wr_addr)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			vld_s1      <= 1'b0;
			valid_q     <= '0;
			mask_q      <= '0;
			pin_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				mask_q <= active_level_mask;
			end
			vld_s1 <= rd_en && (int'(rd_addr) < NUM_CHANNELS) && valid_q[rd_addr];
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			pin_q       <= pin_d;
			out_valid_q <= out_load || (out_valid_q && out_stall);
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cnt_q   <= CW'(1);
						state_q <= (command == CMD_TICK) ? S_TICK : S_CMD;
					end
				end
				S_TICK: begin
					if (rd_en) begin
						cnt_q <= cnt_q + CW'(1);
					end else begin
						state_q <= S_OUT;
					end
				end
				S_CMD: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd_q      <= command;
					idx_q      <= led_index;
					on_q       <= on_time;
					off_q      <= off_time;
					ch_s1      <= rd_addr;
					res_mode_q <= MODE_OFF;
				end
			end
			S_TICK: begin
				if (idx_ok && (ch_s1 == AW'(idx_q))) begin
					res_mode_q <= cur.mode;
				end
				if (rd_en) begin
					ch_s1 <= cnt_q[AW-1:0];
				end
			end
			S_CMD: begin
				res_mode_q <= idx_ok ? nxt.mode : MODE_OFF;
			end
			default: begin
				res_mode_q <= res_mode_q;
			end
		endcase
		if (out_load) begin
			out_pin_q  <= pin_q;
			out_mode_q <= res_mode_q;
		end
	end

	a_onehot_state: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register lost its one-hot code");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_TICK || state_q == S_CMD))
		else $error("accepted request did not start processing");

	a_write_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> ((state_q == S_TICK || state_q == S_CMD)
			&& (int'(wr_addr) < NUM_CHANNELS)))
		else $error("RAM write outside processing or beyond channels");

	a_tick_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TICK) |-> (int'(ch_s1) < NUM_CHANNELS))
		else $error("tick walk channel out of range");

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("result loaded outside the output state");

endmodule

// ----- test/tb_multi_led_flash_controller_unit.sv -----
`timescale 1ns / 100ps

module tb_multi_led_flash_controller_unit;
	import mlfc_pkg::*;

	localparam int          LED_COUNT   = 8;
	localparam logic [2:0]  CMD_RSVD_LO = 3'd5;
	localparam logic [2:0]  CMD_RSVD_HI = 3'd7;
	localparam int          LONG_HOLD   = 300;

	typedef struct packed {
		logic [PIN_W-1:0] pins;
		logic [1:0]       mode;
		logic             active;
	} led_result_t;

	class led_bank_tracker;
		logic [PIN_W-1:0]  level_mask;
		logic [PIN_W-1:0]  pins;
		logic [1:0]        mode      [LED_COUNT];
		bit                phase_lit [LED_COUNT];
		logic [TICK_W-1:0] lit_len   [LED_COUNT];
		logic [TICK_W-1:0] dark_len  [LED_COUNT];
		logic [TICK_W-1:0] countdown [LED_COUNT];
		bit                armed     [LED_COUNT];
		led_result_t       awaited[$];
		int                errors;

		function new();
			level_mask = '0;
			pins       = '0;
			errors     = 0;
			for (int ch = 0; ch < LED_COUNT; ch++) begin
				mode[ch]      = MODE_OFF;
				phase_lit[ch] = 1'b0;
				lit_len[ch]   = '0;
				dark_len[ch]  = '0;
				countdown[ch] = '0;
				armed[ch]     = 1'b0;
			end
		endfunction

		function void drive(int ch, bit lit);
			pins[ch] = (lit == level_mask[ch]);
		endfunction

		function void toggle_phase(int ch);
			phase_lit[ch] = !phase_lit[ch];
			if (phase_lit[ch]) begin
				drive(ch, 1'b1);
				countdown[ch] = lit_len[ch];
				armed[ch]     = 1'b1;
			end else begin
				drive(ch, 1'b0);
				if (dark_len[ch] != '0) begin
					countdown[ch] = dark_len[ch];
					armed[ch]     = 1'b1;
				end else begin
					armed[ch] = 1'b0;
				end
			end
		endfunction

		function void note_request(logic [2:0] cmd, logic [2:0] idx,
		                           logic [TICK_W-1:0] t_on, logic [TICK_W-1:0] t_off);
			led_result_t r;
			case (cmd)
				CMD_TICK: begin
					for (int ch = 0; ch < LED_COUNT; ch++) begin
						if (armed[ch]) begin
							if (countdown[ch] <= 1)
								toggle_phase(ch);
							else
								countdown[ch] = countdown[ch] - 1'b1;
						end
					end
				end
				CMD_ON, CMD_OFF: begin
					mode[idx]  = (cmd == CMD_ON) ? MODE_ON : MODE_OFF;
					armed[idx] = 1'b0;
					drive(idx, cmd == CMD_ON);
				end
				CMD_FLASH, CMD_FLASH_ONCE: begin
					mode[idx]      = MODE_FLASH;
					phase_lit[idx] = 1'b0;
					lit_len[idx]   = t_on;
					dark_len[idx]  = (cmd == CMD_FLASH) ? t_off : '0;
					toggle_phase(idx);
				end
				default: ;
			endcase
			r.pins   = pins;
			r.mode   = mode[idx];
			r.active = (mode[idx] != MODE_OFF);
			awaited.push_back(r);
		endfunction

		function void check_result(logic [PIN_W-1:0] got_pins, logic [1:0] got_mode,
		                           logic got_active);
			led_result_t r;
			if (awaited.size() == 0) begin
				$error("result with no request waiting: pins %h mode %0d active %0d",
				       got_pins, got_mode, got_active);
				errors++;
				return;
			end
			r = awaited.pop_front();
			if (got_pins !== r.pins) begin
				$error("pin_levels: expected %h, got %h", r.pins, got_pins);
				errors++;
			end
			if (got_mode !== r.mode) begin
				$error("mode_of_led: expected %0d, got %0d", r.mode, got_mode);
				errors++;
			end
			if (got_active !== r.active) begin
				$error("led_active: expected %0d, got %0d", r.active, got_active);
				errors++;
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [2:0]        command;
	logic [2:0]        led_index;
	logic [TICK_W-1:0] on_time;
	logic [TICK_W-1:0] off_time;
	logic              out_valid;
	logic              out_stall;
	logic [PIN_W-1:0]  pin_levels;
	logic [1:0]        mode_of_led;
	logic              led_active;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [PIN_W-1:0]  active_level_mask;

	led_bank_tracker tracker = new();
	bit              quiet     = 1'b0;
	bit              long_hold = 1'b0;

	multi_led_flash_controller_unit #(.NUM_CHANNELS(LED_COUNT)) u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.command          (command),
		.led_index        (led_index),
		.on_time          (on_time),
		.off_time         (off_time),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.pin_levels       (pin_levels),
		.mode_of_led      (mode_of_led),
		.led_active       (led_active),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.active_level_mask(active_level_mask)
	);

	always #5 clk = ~clk;

	initial begin
		#2_000_000;
		$display("multi_led_flash_controller_unit test failed");
		$finish;
	end

	initial begin
		out_stall <= 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				long_hold = 1'b0;
				out_stall <= 1'b0;
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 13)) @(negedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_result(pin_levels, mode_of_led, led_active);
	end

	task automatic send_request(logic [2:0] cmd, logic [2:0] idx,
	                            logic [TICK_W-1:0] t_on, logic [TICK_W-1:0] t_off);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		in_valid  <= 1'b1;
		command   <= cmd;
		led_index <= idx;
		on_time   <= t_on;
		off_time  <= t_off;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		tracker.note_request(cmd, idx, t_on, t_off);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (tracker.awaited.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_mask(logic [PIN_W-1:0] value);
		cfg_valid         <= 1'b1;
		active_level_mask <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		tracker.level_mask = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [TICK_W-1:0] pick_duration();
		return ($urandom_range(0, 9) == 0) ? TICK_W'($urandom) : TICK_W'($urandom_range(0, 4));
	endfunction

	task automatic random_request(output bit counted);
		logic [2:0]        cmd;
		logic [2:0]        idx;
		logic [TICK_W-1:0] t_on;
		logic [TICK_W-1:0] t_off;
		int                pick;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			cmd = CMD_TICK;
		else if (pick < 60)
			cmd = CMD_ON;
		else if (pick < 68)
			cmd = CMD_OFF;
		else if (pick < 84)
			cmd = CMD_FLASH;
		else if (pick < 94)
			cmd = CMD_FLASH_ONCE;
		else
			cmd = 3'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
		idx = 3'($urandom_range(0, LED_COUNT - 1));
		if (cmd == CMD_FLASH || cmd == CMD_FLASH_ONCE) begin
			t_on  = pick_duration();
			t_off = pick_duration();
		end else begin
			t_on  = TICK_W'($urandom);
			t_off = TICK_W'($urandom);
		end
		send_request(cmd, idx, t_on, t_off);
		counted = (cmd <= CMD_FLASH_ONCE);
	endtask

	initial begin
		logic [PIN_W-1:0] mask;
		int               n;
		bit               counted;
		arst_n            <= 1'b0;
		in_valid          <= 1'b0;
		command           <= CMD_TICK;
		led_index         <= '0;
		on_time           <= '0;
		off_time          <= '0;
		cfg_valid         <= 1'b0;
		active_level_mask <= '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		write_mask(8'h00);
		send_request(CMD_TICK, 3'd0, 16'h0000, 16'h0000);
		send_request(CMD_ON, 3'd0, 16'h0000, 16'h0000);
		send_request(CMD_ON, 3'd7, 16'hFFFF, 16'hFFFF);
		send_request(CMD_OFF, 3'd0, 16'hFFFF, 16'h0000);
		send_request(CMD_RSVD_LO, 3'd7, 16'hFFFF, 16'hFFFF);
		send_request(CMD_RSVD_LO + 3'd1, 3'd3, 16'h0001, 16'h0001);
		send_request(CMD_RSVD_HI, 3'd0, 16'h0000, 16'h0000);
		send_request(CMD_FLASH, 3'd1, 16'h0000, 16'h0000);
		send_request(CMD_FLASH, 3'd2, 16'h0001, 16'h0001);
		send_request(CMD_FLASH, 3'd3, 16'h0002, 16'hFFFF);
		send_request(CMD_FLASH_ONCE, 3'd4, 16'h0002, 16'hFFFF);
		send_request(CMD_FLASH, 3'd5, 16'hFFFF, 16'h0003);
		repeat (4) send_request(CMD_TICK, 3'd2, 16'hFFFF, 16'hFFFF);
		send_request(CMD_ON, 3'd3, 16'h0000, 16'h0000);
		send_request(CMD_OFF, 3'd2, 16'h0000, 16'h0000);
		repeat (2) send_request(CMD_TICK, 3'd4, 16'h0000, 16'h0000);
		send_request(CMD_FLASH, 3'd7, 16'h0001, 16'h0000);
		repeat (2) send_request(CMD_TICK, 3'd7, 16'h0000, 16'h0000);

		for (int phase = 0; phase < 5; phase++) begin
			wait_drained();
			case (phase)
				0:       mask = 8'hFF;
				3:       mask = 8'h00;
				default: mask = PIN_W'($urandom);
			endcase
			write_mask(mask);
			if (phase == 1)
				long_hold = 1'b1;
			if (phase == 4)
				quiet = 1'b1;
			n = 0;
			while (n < 100) begin
				if (phase == 2 && n == 40)
					wait_drained();
				random_request(counted);
				if (counted)
					n++;
			end
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (tracker.errors == 0 && tracker.awaited.size() == 0)
			$display("multi_led_flash_controller_unit test passed");
		else
			$display("multi_led_flash_controller_unit test failed");
		$finish;
	end

endmodule
